@@ rtl/core/cse_pkg.sv @@
`default_nettype none
package cse_pkg;

    localparam int BYTE_W      = 8;
    localparam int MAX_RUN     = 7;
    localparam int RUN_CNT_W   = 3;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
    localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TILDE  = 8'h7E;
    localparam logic [BYTE_W-1:0] CH_BS     = 8'h08;
    localparam logic [BYTE_W-1:0] CH_FF     = 8'h0C;
    localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
    localparam logic [BYTE_W-1:0] CH_B      = 8'h62;
    localparam logic [BYTE_W-1:0] CH_F      = 8'h66;
    localparam logic [BYTE_W-1:0] CH_N      = 8'h6E;
    localparam logic [BYTE_W-1:0] CH_R      = 8'h72;
    localparam logic [BYTE_W-1:0] CH_T      = 8'h74;
    localparam logic [BYTE_W-1:0] CH_X      = 8'h78;
    localparam logic [BYTE_W-1:0] CH_0      = 8'h30;
    localparam logic [BYTE_W-1:0] CH_9      = 8'h39;
    localparam logic [BYTE_W-1:0] CH_UA     = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UF     = 8'h46;
    localparam logic [BYTE_W-1:0] CH_LA     = 8'h61;
    localparam logic [BYTE_W-1:0] CH_LF_HEX = 8'h66;

    // one expanded item: output text, byte count, closing quote at the end
    typedef struct packed {
        logic [MAX_RUN-1:0][BYTE_W-1:0] text;
        logic [RUN_CNT_W-1:0]           count;
        logic                           has_close;
    } run_t;

    function automatic logic is_hex_char(input logic [BYTE_W-1:0] c);
        return ((c >= CH_0) && (c <= CH_9)) || ((c >= CH_UA) && (c <= CH_UF))
            || ((c >= CH_LA) && (c <= CH_LF_HEX));
    endfunction

    function automatic logic [BYTE_W-1:0] hex_digit(input logic [3:0] nib);
        logic [BYTE_W-1:0] r;
        if (nib < 4'd10)
        begin
            r = CH_0 + {4'd0, nib};
        end
        else
        begin
            r = CH_UA + {4'd0, nib - 4'd10};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/cse_front.sv @@
`default_nettype none
module cse_front
    import cse_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [BYTE_W-1:0] data_byte,
    input  wire logic              starts_string,
    input  wire logic              ends_string,
    input  wire logic              no_data,
    output run_t                   run,
    output logic                   run_nonempty
);

    logic after_hex_reg;
    logic after_hex_next;
    logic hex_flag;
    logic [RUN_CNT_W-1:0] n;

    always_comb
    begin
        run      = '0;
        n        = '0;
        hex_flag = after_hex_reg;
        if (starts_string)
        begin
            run.text[n] = CH_QUOTE;
            n           = n + 1'b1;
            hex_flag    = 1'b0;
        end
        if (!no_data)
        begin
            // break a running hex escape before a hex digit
            if (hex_flag && is_hex_char(data_byte))
            begin
                run.text[n] = CH_QUOTE;
                n           = n + 1'b1;
                run.text[n] = CH_QUOTE;
                n           = n + 1'b1;
            end
            hex_flag = 1'b0;
            if ((data_byte >= CH_SPACE) && (data_byte <= CH_TILDE)
                && (data_byte != CH_BSLASH) && (data_byte != CH_QUOTE))
            begin
                run.text[n] = data_byte;
                n           = n + 1'b1;
            end
            else
            begin
                run.text[n] = CH_BSLASH;
                n           = n + 1'b1;
                if ((data_byte == CH_QUOTE) || (data_byte == CH_BSLASH))
                begin
                    run.text[n] = data_byte;
                    n           = n + 1'b1;
                end
                else if (data_byte == CH_BS)
                begin
                    run.text[n] = CH_B;
                    n           = n + 1'b1;
                end
                else if (data_byte == CH_FF)
                begin
                    run.text[n] = CH_F;
                    n           = n + 1'b1;
                end
                else if (data_byte == CH_LF)
                begin
                    run.text[n] = CH_N;
                    n           = n + 1'b1;
                end
                else if (data_byte == CH_CR)
                begin
                    run.text[n] = CH_R;
                    n           = n + 1'b1;
                end
                else if (data_byte == CH_TAB)
                begin
                    run.text[n] = CH_T;
                    n           = n + 1'b1;
                end
                else
                begin
                    run.text[n] = CH_X;
                    n           = n + 1'b1;
                    run.text[n] = hex_digit(data_byte[7:4]);
                    n           = n + 1'b1;
                    run.text[n] = hex_digit(data_byte[3:0]);
                    n           = n + 1'b1;
                    hex_flag    = 1'b1;
                end
            end
        end
        if (ends_string)
        begin
            run.text[n] = CH_QUOTE;
            n           = n + 1'b1;
            hex_flag    = 1'b0;
        end
        run.count      = n;
        run.has_close  = ends_string;
        run_nonempty   = (n != '0);
        after_hex_next = accept ? hex_flag : after_hex_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            after_hex_reg <= 1'b0;
        end
        else
        begin
            after_hex_reg <= after_hex_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/cse_queue.sv @@
`default_nettype none
module cse_queue
    import cse_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push_valid,
    output logic      push_ready,
    input  run_t      push_run,
    output logic      pop_valid,
    input  wire logic pop_ready,
    output run_t      pop_run
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    run_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             do_push, do_pop;

    assign push_ready = (fill_reg != FULL_CNT);
    assign pop_valid  = (fill_reg != '0);
    assign pop_run    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_run;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/cse_back.sv @@
`default_nettype none
module cse_back
    import cse_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              run_valid,
    output logic                   run_pop,
    input  run_t                   run,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [BYTE_W-1:0]      out_byte,
    output logic                   last_of_run,
    output logic                   string_done
);

    logic [RUN_CNT_W-1:0] idx_reg, idx_next;
    logic                 valid_reg, valid_next;
    logic [BYTE_W-1:0]    byte_reg, byte_next;
    logic                 last_reg, last_next;
    logic                 done_reg, done_next;
    logic                 load;
    logic                 at_end;

    assign load   = run_valid && (!valid_reg || out_ready);
    assign at_end = (idx_reg == run.count - 1'b1);

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg && !out_ready;
        byte_next  = byte_reg;
        last_next  = last_reg;
        done_next  = done_reg;
        run_pop    = 1'b0;
        if (load)
        begin
            valid_next = 1'b1;
            byte_next  = run.text[idx_reg];
            last_next  = at_end;
            done_next  = at_end && run.has_close;
            if (at_end)
            begin
                run_pop  = 1'b1;
                idx_next = '0;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
        done_reg <= done_next;
    end

    assign out_valid   = valid_reg;
    assign out_byte    = byte_reg;
    assign last_of_run = last_reg;
    assign string_done = done_reg;

endmodule
`default_nettype wire

@@ rtl/core/c_string_byte_escaper_core.sv @@
// path: the first output byte of an item is registered in a queue slot and then in the output register
// throughput: one input beat per cycle while items expand to one byte each and out_ready stays high; an
//   item that expands to k bytes (up to 7) goes out one byte per cycle while out_ready allows
// the front accepts ahead while up to QUEUE_DEPTH expanded items wait for the output sequencer
// reset: rst_n asynchronous active low, clears the hex-escape flag, the queue and output valid
`default_nettype none
module c_string_byte_escaper_core
    import cse_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // input beats
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [BYTE_W-1:0] data_byte,
    input  wire logic              starts_string,
    input  wire logic              ends_string,
    input  wire logic              no_data,
    // output beats, one character each
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [BYTE_W-1:0]      out_byte,
    output logic                   last_of_run,
    output logic                   string_done
);

    run_t front_run;
    run_t head_run;
    logic front_nonempty;
    logic q_push_ready;
    logic head_valid;
    logic head_pop;
    logic in_accept;

    // the queue only ever holds items that produce at least one byte, but the
    // input waits on a full queue either way to keep the ready path simple
    assign in_ready  = q_push_ready;
    assign in_accept = in_valid && in_ready;

    // front: expands the beat into its output text and tracks the hex-escape flag
    cse_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (in_accept),
        .data_byte     (data_byte),
        .starts_string (starts_string),
        .ends_string   (ends_string),
        .no_data       (no_data),
        .run           (front_run),
        .run_nonempty  (front_nonempty)
    );

    // short queue decoupling the front from the output sequencer
    cse_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (in_accept && front_nonempty),
        .push_ready (q_push_ready),
        .push_run   (front_run),
        .pop_valid  (head_valid),
        .pop_ready  (head_pop),
        .pop_run    (head_run)
    );

    // back: walks the queued text one byte per cycle, as out_ready allows, into the output register
    cse_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .run_valid   (head_valid),
        .run_pop     (head_pop),
        .run         (head_run),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .last_of_run (last_of_run),
        .string_done (string_done)
    );

endmodule
`default_nettype wire
